// ===== rtl/bep_pkg.sv =====
// Shared types and constants for the byte entropy pool.
package bep_pkg;

   localparam logic [1:0] ACT_RESEED = 2'd0;
   localparam logic [1:0] ACT_MIX    = 2'd1;
   localparam logic [1:0] ACT_DRAW   = 2'd2;

   localparam int unsigned GEN_WIDTH = 31;
   localparam logic [GEN_WIDTH-1:0] GEN_BASE = 31'h5EAD_BEEF;
   localparam logic [GEN_WIDTH-1:0] GEN_MUL  = 31'd1103515245;
   localparam logic [GEN_WIDTH-1:0] GEN_ADD  = 31'd12345;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic [4:0]  byte_count;
      logic [31:0] seed;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_MIX_WR,
      ST_DRAW_RD,
      ST_DRAW_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic load_seed;
      logic fill_step;
      logic mix_write;
      logic draw_out;
   } cmd_type;

   typedef struct packed {
      logic fill_done;
      logic rsp_free;
      logic cnt_last;
      logic count_zero;
   } status_type;

endpackage

// ===== rtl/bep_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bep_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bep_ctrl.sv =====
// Controller state machine sequencing fill, mix and draw operations.
module bep_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_action,
   input  bep_pkg::status_type status,
   output bep_pkg::cmd_type    cmd,
   output logic                req_ready
);
   import bep_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (status.fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_RESEED: state_in = ST_FILL;
                  ACT_MIX:    state_in = ST_MIX_WR;
                  ACT_DRAW:   state_in = status.count_zero ? ST_IDLE : ST_DRAW_OUT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MIX_WR:  state_in = ST_IDLE;
         ST_DRAW_RD: state_in = ST_DRAW_OUT;
         ST_DRAW_OUT: begin
            if (status.rsp_free) begin
               state_in = status.cnt_last ? ST_IDLE : ST_DRAW_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_FILL: cmd.fill_step = 1'b1;
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_req  = accept;
            cmd.load_seed = accept && (req_action == ACT_RESEED);
         end
         ST_MIX_WR:   cmd.mix_write = 1'b1;
         ST_DRAW_RD:  cmd = '0;
         ST_DRAW_OUT: cmd.draw_out = status.rsp_free;
         default:     cmd = '0;
      endcase
   end

endmodule

// ===== rtl/bep_datapath.sv =====
// Datapath holding the pool memory, position, generator, run counter and result register.
module bep_datapath #(
   parameter int unsigned POOL_DEPTH = 4096,
   parameter int unsigned MAX_RUN    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  bep_pkg::req_type    req_data,
   input  bep_pkg::cmd_type    cmd,
   output bep_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bep_pkg::rsp_type    rsp_data
);
   import bep_pkg::*;

   localparam int unsigned PW = $clog2(POOL_DEPTH);
   localparam int unsigned CW = $clog2(MAX_RUN + 1);

   logic [GEN_WIDTH-1:0] gen_ff, gen_in, gen_next;
   logic [PW-1:0]        idx_ff, idx_in;
   logic [PW-1:0]        pos_ff, pos_in, pos_inc;
   logic [CW-1:0]        cnt_ff, cnt_in, cnt_sat;
   logic [7:0]           data_ff, data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 wr_en;
   logic [PW-1:0]        wr_addr;
   logic [7:0]           wr_data;
   logic [7:0]           rd_data;

   assign gen_next = gen_ff * GEN_MUL + GEN_ADD;
   assign pos_inc  = (pos_ff == PW'(POOL_DEPTH - 1)) ? '0 : pos_ff + PW'(1);
   assign cnt_sat  = (int'(req_data.byte_count) > MAX_RUN) ? CW'(MAX_RUN)
                                                          : CW'(req_data.byte_count);

   always_comb begin
      gen_in       = gen_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_req) begin
         data_in = req_data.data_byte;
         cnt_in  = cnt_sat;
      end
      if (cmd.load_seed) begin
         gen_in = req_data.seed[GEN_WIDTH-1:0] ^ GEN_BASE;
         idx_in = '0;
         pos_in = '0;
      end
      if (cmd.fill_step) begin
         gen_in = gen_next;
         idx_in = idx_ff + PW'(1);
      end
      if (cmd.mix_write) begin
         pos_in = pos_inc;
      end
      if (cmd.draw_out) begin
         pos_in             = pos_inc;
         cnt_in             = cnt_ff - CW'(1);
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = rd_data;
         rsp_in.last_of_run = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= GEN_BASE;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff  <= cnt_in;
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      wr_en   = cmd.fill_step || cmd.mix_write || cmd.draw_out;
      wr_addr = cmd.fill_step ? idx_ff : pos_ff;
      if (cmd.fill_step) begin
         wr_data = gen_next[23:16];
      end else if (cmd.mix_write) begin
         wr_data = rd_data ^ data_ff;
      end else begin
         wr_data = {rd_data[6:0], rd_data[7]};
      end
   end

   bep_ram #(
      .WIDTH(8),
      .DEPTH(POOL_DEPTH)
   ) u_pool (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(pos_ff),
      .rd_data(rd_data)
   );

   assign status.fill_done  = (idx_ff == PW'(POOL_DEPTH - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.cnt_last   = (cnt_ff == CW'(1));
   assign status.count_zero = (req_data.byte_count == 5'd0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/byte_entropy_pool_core.sv =====
// Top level of the byte entropy pool: controller and datapath.
// The pool is a single RAM of POOL_DEPTH bytes with one write and one registered read
// port, filled by a 31-bit linear congruential generator that steps once per cycle.
// After reset the block fills the pool with req_ready low; a reseed item does the
// same. Each byte of a draw item needs a RAM read and then a read-modify-write of the
// same entry, and a byte waits while the result register holds a byte not yet taken.
// A draw item with a zero byte count, or an item with an unused action code, produces
// nothing. The result register lets the next item be accepted while the last byte of
// a run is still waiting to be taken.
module byte_entropy_pool_core #(
   parameter int unsigned POOL_DEPTH = 4096,
   parameter int unsigned MAX_RUN    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bep_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bep_pkg::rsp_type rsp_data
);
   import bep_pkg::*;

   cmd_type    cmd;
   status_type status;

   bep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_data.action),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   bep_datapath #(
      .POOL_DEPTH(POOL_DEPTH),
      .MAX_RUN   (MAX_RUN)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/byte_entropy_pool_core_test.sv =====
// Self-checking testbench for the byte entropy pool core, driven by directed and random items.
`timescale 1ns / 100ps

module byte_entropy_pool_core_test;
   import bep_pkg::*;

   localparam int unsigned POOL_DEPTH   = 4096;
   localparam int unsigned MAX_RUN      = 16;
   localparam int unsigned RANDOM_ITEMS = 100;
   localparam int unsigned MAX_RESEEDS  = 12;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned TAIL_CYCLES  = 64;

   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam logic [30:0] LCG_START  = 31'h5EAD_BEEF;
   localparam logic [30:0] LCG_MUL    = 31'd1103515245;
   localparam logic [30:0] LCG_INC    = 31'd12345;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0]  pool_image [POOL_DEPTH];
   logic [11:0] position_image;
   rsp_type     drawn_bytes_q [$];

   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   logic [8:0]  stall_phase = '0;
   int unsigned burst_left  = 1;
   bit          gaps_off    = 1'b0;
   bit          valid_high  = 1'b0;

   byte_entropy_pool_core #(
      .POOL_DEPTH(POOL_DEPTH),
      .MAX_RUN   (MAX_RUN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      stall_phase <= stall_phase + 9'd1;
      case (stall_phase[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ready <= stall_phase[3];
      endcase
   end

   function automatic void refill_pool(input logic [31:0] seed);
      logic [30:0] lcg;
      lcg = LCG_START ^ seed[30:0];
      for (int i = 0; i < POOL_DEPTH; i++) begin
         lcg = lcg * LCG_MUL + LCG_INC;
         pool_image[i] = lcg[23:16];
      end
      position_image = '0;
   endfunction

   function automatic void predict_item(input req_type item);
      logic [4:0] run_len;
      logic [7:0] entry;
      rsp_type    drawn;
      run_len = (item.byte_count > MAX_RUN) ? 5'(MAX_RUN) : item.byte_count;
      case (item.action)
         ACT_RESEED: refill_pool(item.seed);
         ACT_MIX: begin
            pool_image[position_image] = pool_image[position_image] ^ item.data_byte;
            position_image = position_image + 12'd1;
         end
         ACT_DRAW: begin
            for (int k = 0; k < run_len; k++) begin
               entry = pool_image[position_image];
               drawn.out_byte = entry;
               drawn.last_of_run = (k == run_len - 1);
               drawn_bytes_q.push_back(drawn);
               pool_image[position_image] = {entry[6:0], entry[7]};
               position_image = position_image + 12'd1;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d (%s): expected byte %02h last %0d, got byte %02h last %0d",
                  mismatches, what, want.out_byte, want.last_of_run,
                  got.out_byte, got.last_of_run);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drawn_bytes_q.size() == 0) begin
            log_mismatch("no result expected", '0, rsp_data);
         end else begin
            want = drawn_bytes_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               log_mismatch("out_byte", want, rsp_data);
            if (rsp_data.last_of_run !== want.last_of_run)
               log_mismatch("last_of_run", want, rsp_data);
         end
      end
   end

   function automatic req_type make_item(input logic [1:0] action, input logic [7:0] data,
                                         input logic [4:0] count, input logic [31:0] seed);
      req_type item;
      item.action     = action;
      item.data_byte  = data;
      item.byte_count = count;
      item.seed       = seed;
      return item;
   endfunction

   task automatic rest_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      valid_high = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      valid_high = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(item);
      if (!gaps_off) begin
         burst_left--;
         if (burst_left == 0) begin
            rest_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   task automatic drain_results();
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
      end
      do @(posedge clock); while (drawn_bytes_q.size() != 0);
   endtask

   task automatic test_reset_fill();
      send_item(make_item(ACT_DRAW, 8'h00, 5'd16, 32'h0));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd5, 32'h0));
   endtask

   task automatic test_special_cases();
      send_item(make_item(ACT_UNUSED, 8'hFF, 5'd31, 32'hFFFF_FFFF));
      send_item(make_item(ACT_DRAW, 8'hFF, 5'd0, 32'hFFFF_FFFF));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd31, 32'h0));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd17, 32'h0));
      send_item(make_item(ACT_MIX, 8'hFF, 5'd0, 32'h0));
      send_item(make_item(ACT_MIX, 8'h00, 5'd31, 32'hFFFF_FFFF));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd1, 32'h0));
      send_item(make_item(ACT_RESEED, 8'h00, 5'd0, 32'hFFFF_FFFF));
      send_item(make_item(ACT_DRAW, 8'hA5, 5'd4, 32'h0));
      send_item(make_item(ACT_RESEED, 8'hFF, 5'd31, 32'h8000_0000));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd3, 32'h0));
      send_item(make_item(ACT_RESEED, 8'h00, 5'd16, 32'h7FFF_FFFF));
      send_item(make_item(ACT_MIX, 8'h5A, 5'd16, 32'h0));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd2, 32'h0));
      send_item(make_item(ACT_RESEED, 8'h00, 5'd1, 32'hDEAD_BEEF));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd16, 32'h0));
   endtask

   // The pool is walked almost to its end by full draws and a few mix items so that the
   // first of the last two draws crosses the wrap.
   task automatic test_position_wrap();
      gaps_off = 1'b1;
      send_item(make_item(ACT_RESEED, 8'h00, 5'd0, $urandom()));
      for (int i = 0; i < (POOL_DEPTH - 6) / MAX_RUN; i++)
         send_item(make_item(ACT_DRAW, 8'h00, 5'(MAX_RUN), 32'h0));
      for (int i = 0; i < (POOL_DEPTH - 6) % MAX_RUN; i++)
         send_item(make_item(ACT_MIX, 8'($urandom_range(0, 255)), 5'd1, 32'h0));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd16, 32'h0));
      send_item(make_item(ACT_DRAW, 8'h00, 5'd16, 32'h0));
      gaps_off = 1'b0;
   endtask

   task automatic test_random_traffic();
      req_type     item;
      int unsigned accepted_items;
      int unsigned reseeds;
      int unsigned pick;
      bit          drained;
      accepted_items = 0;
      reseeds = 0;
      drained = 1'b0;
      while (accepted_items < RANDOM_ITEMS) begin
         gaps_off = (accepted_items >= 30 && accepted_items < 55);
         if (accepted_items == 65 && !drained) begin
            drain_results();
            drained = 1'b1;
         end
         item = make_item(ACT_DRAW, 8'($urandom_range(0, 255)),
                          5'($urandom_range(1, MAX_RUN)), $urandom());
         pick = $urandom_range(0, 99);
         if (pick < 3 && reseeds < MAX_RESEEDS) begin
            item.action = ACT_RESEED;
            reseeds++;
            accepted_items++;
         end else if (pick < 38) begin
            item.action = ACT_MIX;
            accepted_items++;
         end else if (pick < 88) begin
            accepted_items++;
         end else if (pick < 92) begin
            item.byte_count = 5'($urandom_range(MAX_RUN + 1, 31));
            accepted_items++;
         end else if (pick < 96) begin
            item.byte_count = '0;
         end else begin
            item.action = ACT_UNUSED;
            item.byte_count = 5'($urandom_range(0, 31));
         end
         send_item(item);
      end
   endtask

   initial begin
      refill_pool(32'd0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_fill();
      test_special_cases();
      test_position_wrap();
      test_random_traffic();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && drawn_bytes_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
